@@ hdl/lmms_pkg.sv @@
// ============================================================================
// LED matrix marquee scroller package
// Shared transaction types and fixed constants for the marquee scroller.
// ============================================================================
package lmms_pkg;

    // Glyph geometry: 16 rows of two bytes each.
    localparam int GLYPH_BYTES      = 32;
    localparam int GLYPH_BYTES_LOG2 = 5;
    localparam int GLYPH_ROWS       = 16;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ROTATE = 2'd1;
    localparam logic [1:0] MODE_SHOW   = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_index;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0] chip;
        logic [3:0] digit_register;
        logic [7:0] segment_byte;
        logic       last;
    } out_item_t;

endpackage

@@ hdl/lmms_ram.sv @@
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module lmms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/led_matrix_marquee_scroller.sv @@
// ============================================================================
// LED matrix marquee scroller
// Frame buffer of 16x16 glyphs with load, one-column ring rotate and
// display-driver register write generation for the first glyph.
// ============================================================================
// The block keeps MAX_CHARS glyphs of 16x16 pixels in a RAM with one
// write port and one read port, 32 bytes per glyph, each row stored as its
// left byte then its right byte. An input transaction is taken only while
// the block is idle. A rotate first reads the left byte of every row of
// glyph 0 to save the bits that wrap around, then rewrites every byte of
// the ring by reading it, reading its neighbor and writing it, one byte at
// a time through the single RAM read port. A show produces 32 output
// transactions, one at a time: each register write must be taken before
// the next byte is read. The char_count register is written through its
// own channel, which is always ready; values of zero act as one and values
// above MAX_CHARS act as MAX_CHARS. Frame buffer bytes read before they
// were loaded give undefined pixels.
// ============================================================================
module led_matrix_marquee_scroller #(
    parameter int MAX_CHARS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lmms_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lmms_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);

    localparam int BUF_BYTES = MAX_CHARS * lmms_pkg::GLYPH_BYTES;
    localparam int AW        = $clog2(BUF_BYTES);
    localparam int CW        = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP_RD,
        S_WRAP_CAP,
        S_ROT_RD_CUR,
        S_ROT_RD_NB,
        S_ROT_WR,
        S_SHOW_RD,
        S_SHOW_LOAD,
        S_SHOW_WAIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [15:0]         wrap_reg, wrap_next;
    logic [7:0]          cur_reg, cur_next;
    logic [3:0]          char_count_reg, char_count_next;
    logic                out_valid_reg, out_valid_next;
    lmms_pkg::out_item_t out_reg, out_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [7:0]          ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;

    logic                in_fire;
    logic [CW-1:0]       ring_len;
    logic [CW-1:0]       cnt_inc;
    logic                wrap_case;
    logic                in_bit;

    lmms_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Ring length in bytes, with the glyph count clamped to the legal range.
    always_comb
    begin
        if (char_count_reg == 4'd0)
        begin
            ring_len = CW'(lmms_pkg::GLYPH_BYTES);
        end
        else if (32'(char_count_reg) > MAX_CHARS)
        begin
            ring_len = CW'(BUF_BYTES);
        end
        else
        begin
            ring_len = CW'(char_count_reg) << lmms_pkg::GLYPH_BYTES_LOG2;
        end
    end

    assign cnt_inc = cnt_reg + CW'(1);

    // The right byte of a row in the last glyph takes its new bit from the
    // saved left byte of the same row of glyph 0.
    assign wrap_case = (cnt_reg + CW'(lmms_pkg::GLYPH_BYTES)) >= len_reg;
    assign in_bit    = (cnt_reg[0] && wrap_case) ? wrap_reg[cnt_reg[4:1]] : ram_rdata[7];

    // RAM read address for the current step.
    always_comb
    begin
        case (state_reg)
            S_WRAP_RD:
            begin
                ram_raddr = AW'({cnt_reg[3:0], 1'b0});
            end
            S_ROT_RD_CUR, S_SHOW_RD:
            begin
                ram_raddr = cnt_reg[AW-1:0];
            end
            S_ROT_RD_NB:
            begin
                if (cnt_reg[0])
                begin
                    ram_raddr = cnt_reg[AW-1:0] + AW'(lmms_pkg::GLYPH_BYTES - 1);
                end
                else
                begin
                    ram_raddr = cnt_reg[AW-1:0] + AW'(1);
                end
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // RAM write port: loads while idle, rotated bytes during a rotate.
    always_comb
    begin
        if (state_reg == S_ROT_WR)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[AW-1:0];
            ram_wdata = {cur_reg[6:0], in_bit};
        end
        else
        begin
            ram_we    = in_fire && (in_data.mode == lmms_pkg::MODE_LOAD) &&
                        (32'(in_data.byte_index) < BUF_BYTES);
            ram_waddr = AW'(in_data.byte_index);
            ram_wdata = in_data.byte_value;
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        wrap_next       = wrap_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        char_count_next = char_count_reg;

        if (cfg_valid && cfg_ready)
        begin
            char_count_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    case (in_data.mode)
                        lmms_pkg::MODE_ROTATE:
                        begin
                            len_next   = ring_len;
                            state_next = S_WRAP_RD;
                        end
                        lmms_pkg::MODE_SHOW:
                        begin
                            state_next = S_SHOW_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRAP_RD:
            begin
                state_next = S_WRAP_CAP;
            end
            S_WRAP_CAP:
            begin
                wrap_next[cnt_reg[3:0]] = ram_rdata[7];
                if (cnt_reg[3:0] == 4'(lmms_pkg::GLYPH_ROWS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ROT_RD_CUR;
                end
                else
                begin
                    cnt_next   = cnt_inc;
                    state_next = S_WRAP_RD;
                end
            end
            S_ROT_RD_CUR:
            begin
                state_next = S_ROT_RD_NB;
            end
            S_ROT_RD_NB:
            begin
                cur_next   = ram_rdata;
                state_next = S_ROT_WR;
            end
            S_ROT_WR:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == len_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ROT_RD_CUR;
                end
            end
            S_SHOW_RD:
            begin
                state_next = S_SHOW_LOAD;
            end
            S_SHOW_LOAD:
            begin
                // Chips alternate by byte parity, the quadrant by the upper half.
                out_next.chip           = {~cnt_reg[0], ~cnt_reg[4]};
                out_next.digit_register = {1'b0, cnt_reg[3:1]} + 4'd1;
                out_next.segment_byte   = ram_rdata;
                out_next.last           = (cnt_reg[4:0] == 5'(lmms_pkg::GLYPH_BYTES - 1));
                out_valid_next          = 1'b1;
                state_next              = S_SHOW_WAIT;
            end
            S_SHOW_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        state_next = S_SHOW_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            len_reg        <= '0;
            wrap_reg       <= '0;
            cur_reg        <= '0;
            char_count_reg <= 4'd1;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            len_reg        <= len_next;
            wrap_reg       <= wrap_next;
            cur_reg        <= cur_next;
            char_count_reg <= char_count_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

endmodule

@@ verif/testbench.sv @@
// ============================================================================
// Marquee scroller testbench
// Drives load, rotate, show and unused-mode commands into the scroller, keeps
// a shadow frame buffer to work out the display-driver register writes that
// each show must produce, and compares every write that comes out against
// them while the sender and the receiver idle at random.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GLYPHS    = 8;
    localparam int BUFFER_BYTES  = MAX_GLYPHS * lmms_pkg::GLYPH_BYTES;
    // A rotate over eight glyphs may still be running after the last
    // transaction, so this is how long the block is given to finish.
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASES        = 7;
    // The mode value that the block ignores.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    lmms_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    lmms_pkg::out_item_t out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [3:0]          cfg_data  = 4'd0;

    // Commands waiting to be offered, and register writes waiting to appear.
    lmms_pkg::in_item_t  pending_commands[$];
    lmms_pkg::out_item_t expected_writes[$];

    // Shadow of the block: frame buffer contents and the glyph count register.
    logic [7:0] shadow_frame [BUFFER_BYTES];
    logic [3:0] shadow_char_count = 4'd1;

    // Which buffer bytes the stimulus has loaded so far. A rotate or a show is
    // only queued once every byte it reads is marked here.
    bit glyph_byte_loaded [BUFFER_BYTES];

    int send_idle_pct = 22;
    int recv_idle_pct = 61;
    int error_count   = 0;
    int cycle_count   = 0;
    int queued_count  = 0;
    int hold_left     = 0;
    bit hold_arm      = 1'b0;
    bit hold_started  = 1'b0;
    lmms_pkg::out_item_t want_write;

    led_matrix_marquee_scroller #(
        .MAX_CHARS (MAX_GLYPHS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // The register value 0 behaves as one glyph and anything above the buffer
    // size behaves as the full buffer.
    function automatic int ring_glyphs(logic [3:0] count);
        if (count == 4'd0)
            return 1;
        if (int'(count) > MAX_GLYPHS)
            return MAX_GLYPHS;
        return int'(count);
    endfunction

    // Updates the shadow buffer for one accepted command and queues the
    // register writes that a show produces.
    task automatic apply_marquee_command(lmms_pkg::in_item_t cmd);
        logic [7:0]          snap [BUFFER_BYTES];
        logic [15:0]         wrap_bits;
        logic                in_bit;
        lmms_pkg::out_item_t w;
        int                  len;
        case (cmd.mode)
            lmms_pkg::MODE_LOAD:
            begin
                if (int'(cmd.byte_index) < BUFFER_BYTES)
                    shadow_frame[cmd.byte_index] = cmd.byte_value;
            end
            lmms_pkg::MODE_ROTATE:
            begin
                // Every pixel row is one ring of bits across the glyphs. The
                // left byte takes the top bit of its own right byte, the right
                // byte takes the top bit of the next glyph's left byte, and
                // the last glyph takes the bits that fell off glyph 0.
                len  = ring_glyphs(shadow_char_count) * lmms_pkg::GLYPH_BYTES;
                snap = shadow_frame;
                for (int r = 0; r < lmms_pkg::GLYPH_ROWS; r++)
                begin
                    wrap_bits[r] = snap[2 * r][7];
                end
                for (int i = 0; i < len; i++)
                begin
                    if (i % 2 == 0)
                        in_bit = snap[i + 1][7];
                    else if (i + lmms_pkg::GLYPH_BYTES < len)
                        in_bit = snap[i + lmms_pkg::GLYPH_BYTES - 1][7];
                    else
                        in_bit = wrap_bits[(i % lmms_pkg::GLYPH_BYTES) / 2];
                    shadow_frame[i] = {snap[i][6:0], in_bit};
                end
            end
            lmms_pkg::MODE_SHOW:
            begin
                // The top half of glyph 0 goes to chips 3 and 1, the bottom
                // half to chips 2 and 0, left bytes on the higher-numbered chip.
                for (int i = 0; i < lmms_pkg::GLYPH_BYTES; i++)
                begin
                    if (i < 16)
                    begin
                        w.chip           = (i % 2 == 0) ? 2'd3 : 2'd1;
                        w.digit_register = 4'(i / 2 + 1);
                    end
                    else
                    begin
                        w.chip           = (i % 2 == 0) ? 2'd2 : 2'd0;
                        w.digit_register = 4'(i / 2 - 7);
                    end
                    w.segment_byte = shadow_frame[i];
                    w.last         = (i == lmms_pkg::GLYPH_BYTES - 1);
                    expected_writes.push_back(w);
                end
            end
            default:
            begin
                // The unused mode leaves everything as it is.
            end
        endcase
    endtask

    task automatic push_command(logic [1:0] mode, logic [7:0] index, logic [7:0] value);
        lmms_pkg::in_item_t cmd;
        cmd.mode       = mode;
        cmd.byte_index = index;
        cmd.byte_value = value;
        if (mode == lmms_pkg::MODE_LOAD)
            glyph_byte_loaded[index] = 1'b1;
        pending_commands.push_back(cmd);
        queued_count++;
    endtask

    // Loads random pixels into any byte below nbytes that was never written,
    // so that the rotate or show that follows reads only defined data.
    task automatic load_unwritten(int nbytes);
        for (int b = 0; b < nbytes; b++)
        begin
            if (!glyph_byte_loaded[b])
                push_command(lmms_pkg::MODE_LOAD, 8'(b), 8'($urandom_range(255)));
        end
    endtask

    task automatic push_rotate();
        load_unwritten(ring_glyphs(shadow_char_count) * lmms_pkg::GLYPH_BYTES);
        push_command(lmms_pkg::MODE_ROTATE, 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    endtask

    task automatic push_show();
        load_unwritten(lmms_pkg::GLYPH_BYTES);
        push_command(lmms_pkg::MODE_SHOW, 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    endtask

    // Random commands for one phase: scrolling runs of one to three rotates
    // and a show, loose loads, rotates and shows, row rewrites with a show,
    // and unused-mode noise. Every queued command counts, priming loads too.
    task automatic queue_random_commands(int count);
        int start;
        int pick;
        int n;
        int row;
        start = queued_count;
        while (queued_count - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                n = $urandom_range(3, 1);
                for (int k = 0; k < n; k++)
                begin
                    push_rotate();
                end
                push_show();
            end
            else if (pick < 58)
            begin
                push_command(lmms_pkg::MODE_LOAD, 8'($urandom_range(255)),
                             8'($urandom_range(255)));
            end
            else if (pick < 68)
            begin
                push_rotate();
            end
            else if (pick < 82)
            begin
                push_show();
            end
            else if (pick < 90)
            begin
                push_command(MODE_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else
            begin
                row = $urandom_range(lmms_pkg::GLYPH_ROWS - 1);
                push_command(lmms_pkg::MODE_LOAD, 8'(2 * row), 8'($urandom_range(255)));
                push_command(lmms_pkg::MODE_LOAD, 8'(2 * row + 1), 8'($urandom_range(255)));
                push_show();
            end
        end
    endtask

    // Waits until every command has been taken and every write has arrived,
    // then lets the block finish a rotate that may still be running. The
    // check runs at the falling edge, after the driver has settled.
    task automatic wait_idle();
        while (pending_commands.size() != 0 || in_valid || expected_writes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_char_count(logic [3:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        shadow_char_count = value;
        cfg_valid <= 1'b0;
    endtask

    // Driver: offers the queued commands one transaction at a time. A command
    // that is not yet taken stays on the port unchanged; otherwise the next one
    // is offered unless the sender decides to idle this cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_marquee_command(in_data);
            if (in_valid && !in_ready)
            begin
                // Hold the offered command until it is taken.
            end
            else if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_commands.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every register write against the oldest expected one and
    // drives out_ready. Once armed, it holds out_ready low for a long stretch
    // so that a show backs up and the block stops taking commands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            hold_left    <= 0;
            hold_started <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected write: chip %0d reg %0d seg %h last %0d",
                                 out_data.chip, out_data.digit_register,
                                 out_data.segment_byte, out_data.last);
                end
                else
                begin
                    want_write = expected_writes.pop_front();
                    if (out_data.chip !== want_write.chip ||
                        out_data.digit_register !== want_write.digit_register ||
                        out_data.segment_byte !== want_write.segment_byte ||
                        out_data.last !== want_write.last)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("write mismatch: expected chip %0d reg %0d seg %h last %0d,",
                                     want_write.chip, want_write.digit_register,
                                     want_write.segment_byte, want_write.last,
                                     " got chip %0d reg %0d seg %h last %0d",
                                     out_data.chip, out_data.digit_register,
                                     out_data.segment_byte, out_data.last);
                    end
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_arm && !hold_started)
            begin
                out_ready    <= 1'b0;
                hold_left    <= HOLD_CYCLES;
                hold_started <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus: a directed opening at the reset glyph count, then random
    // phases, each started with a new glyph count while the block is idle.
    initial
    begin
        int phase_count [PHASES];
        int phase_items [PHASES];
        int phase_idle  [PHASES];

        phase_count = '{2, 0, 3, 8, 15, 1, 5};
        phase_items = '{24, 8, 24, 164, 10, 12, 12};
        phase_idle  = '{0, 0, 1, 1, 1, 2, 2};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Extreme bytes at both ends of the buffer and of glyph 0, unused-mode
        // commands with all field bits at both values, then shows and single
        // glyph rotates, where every row wraps onto itself.
        push_command(lmms_pkg::MODE_LOAD, 8'd0, 8'hFF);
        push_command(lmms_pkg::MODE_LOAD, 8'd1, 8'h00);
        push_command(lmms_pkg::MODE_LOAD, 8'd30, 8'h80);
        push_command(lmms_pkg::MODE_LOAD, 8'd31, 8'h01);
        push_command(lmms_pkg::MODE_LOAD, 8'd255, 8'h00);
        push_command(lmms_pkg::MODE_LOAD, 8'd128, 8'hAA);
        push_command(MODE_UNUSED, 8'hFF, 8'hFF);
        push_command(MODE_UNUSED, 8'h00, 8'h00);
        push_show();
        push_rotate();
        push_show();
        push_command(lmms_pkg::MODE_LOAD, 8'd2, 8'h7F);
        push_command(lmms_pkg::MODE_LOAD, 8'd3, 8'hFE);
        push_rotate();
        push_rotate();
        push_show();
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_char_count(4'(phase_count[p]));
            case (phase_idle[p])
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 61;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p == 2)
            begin
                // Two shows up front while the receiver is held off: the first
                // one fills the output side and the second waits at the input.
                hold_arm = 1'b1;
                push_show();
                push_show();
            end
            queue_random_commands(phase_items[p]);
            wait_idle();
        end

        error_count += expected_writes.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
